[rtl/core/png_stored_deflate_encoder_top_defines.svh]
// Assertion macros for the stored-deflate PNG encoder.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef PNG_STORED_DEFLATE_ENCODER_TOP_DEFINES_SVH
`define PNG_STORED_DEFLATE_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define PSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("psd assertion failed");

// Next-cycle implication, ignored while reset is held.
`define PSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("psd assertion failed");

`endif

[rtl/core/psd_pkg.sv]
// Shared types, constants and functions for the stored-deflate PNG encoder.
// No dependencies.
`timescale 1ns / 1ps
package psd_pkg;

    localparam int RAW_W = 35;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [15:0] STORED_MAX = 16'hFFFF;

    localparam logic [63:0] PNG_SIG   = 64'h89504E470D0A1A0A;
    localparam logic [31:0] IHDR_LEN  = 32'd13;
    localparam logic [31:0] TAG_IHDR  = 32'h49484452;
    localparam logic [31:0] TAG_IDAT  = 32'h49444154;
    localparam logic [31:0] TAG_IEND  = 32'h49454E44;
    localparam logic [7:0]  BIT_DEPTH = 8'd8;
    localparam logic [7:0]  COLOR_RGBA = 8'd6;
    localparam logic [7:0]  ZLIB_CMF  = 8'h78;
    localparam logic [7:0]  ZLIB_FLG  = 8'h01;
    localparam logic [7:0]  FILTER_NONE = 8'h00;

    // Sequence lengths (last index) of the emitted runs.
    localparam logic [5:0] HDR_LAST = 6'd42;
    localparam logic [5:0] BLK_LAST = 6'd4;
    localparam logic [5:0] TRL_LAST = 6'd19;

    localparam logic [7:0] CFG_WIDTH  = 8'd0;
    localparam logic [7:0] CFG_HEIGHT = 8'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_BLK,
        ST_FILT,
        ST_PIX,
        ST_TRL
    } t_state;

    typedef struct packed {
        t_state     src;
        logic [5:0] idx;
        logic       fire;
        logic       run_last;
        logic       file_last;
        logic       take;
        logic       latch_img;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic row_start;
        logic blk_empty;
        logic blk_last;
        logic img_end;
    } t_sts;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] k);
        logic [7:0] r;
        unique case (k)
            2'd0: r = w[31:24];
            2'd1: r = w[23:16];
            2'd2: r = w[15:8];
            default: r = w[7:0];
        endcase
        return r;
    endfunction

endpackage

[rtl/core/psd_in_if.sv]
// Pixel byte input channel.
// No dependencies.
`timescale 1ns / 1ps
interface psd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

[rtl/core/psd_out_if.sv]
// PNG byte output channel.
// No dependencies.
`timescale 1ns / 1ps
interface psd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       file_last;
    modport source (output valid, output out_byte, output run_last, output file_last,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input file_last,
                    output ready);
endinterface

[rtl/core/psd_cfg_if.sv]
// Configuration write channel.
// No dependencies.
`timescale 1ns / 1ps
interface psd_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/psd_ctrl.sv]
// Sequencer of the stored-deflate PNG encoder: walks header, block header,
// raw byte and trailer runs. Depends on psd_pkg.
`timescale 1ns / 1ps
module psd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  psd_pkg::t_sts i_sts,
    output psd_pkg::t_cmd o_cmd
);

    psd_pkg::t_state r_state, n_state;
    psd_pkg::t_state r_ret, n_ret;
    logic [5:0]      r_idx, n_idx;
    logic            r_active, n_active;
    logic            w_fire;

    assign w_fire = i_sts.out_free && (r_state != psd_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= psd_pkg::ST_IDLE;
            r_ret    <= psd_pkg::ST_FILT;
            r_idx    <= '0;
            r_active <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_idx    <= n_idx;
            r_active <= n_active;
        end
    end

    // Next state
    always_comb begin
        n_state  = r_state;
        n_ret    = r_ret;
        n_idx    = r_idx;
        n_active = r_active;
        unique case (r_state)
            psd_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_idx = '0;
                    if (!r_active) begin
                        n_state  = psd_pkg::ST_HDR;
                        n_active = 1'b1;
                    end else begin
                        n_ret = i_sts.row_start ? psd_pkg::ST_FILT : psd_pkg::ST_PIX;
                        n_state = i_sts.blk_empty ? psd_pkg::ST_BLK : n_ret;
                    end
                end
            end
            psd_pkg::ST_HDR: begin
                if (w_fire) begin
                    n_idx = r_idx + 6'd1;
                    if (r_idx == psd_pkg::HDR_LAST) begin
                        n_idx   = '0;
                        n_ret   = psd_pkg::ST_FILT;
                        n_state = psd_pkg::ST_BLK;
                    end
                end
            end
            psd_pkg::ST_BLK: begin
                if (w_fire) begin
                    n_idx = r_idx + 6'd1;
                    if (r_idx == psd_pkg::BLK_LAST) begin
                        n_idx   = '0;
                        n_state = r_ret;
                    end
                end
            end
            psd_pkg::ST_FILT: begin
                if (w_fire) begin
                    n_idx   = '0;
                    n_ret   = psd_pkg::ST_PIX;
                    n_state = i_sts.blk_last ? psd_pkg::ST_BLK : psd_pkg::ST_PIX;
                end
            end
            psd_pkg::ST_PIX: begin
                if (w_fire) begin
                    n_idx   = '0;
                    n_state = i_sts.img_end ? psd_pkg::ST_TRL : psd_pkg::ST_IDLE;
                end
            end
            psd_pkg::ST_TRL: begin
                if (w_fire) begin
                    n_idx = r_idx + 6'd1;
                    if (r_idx == psd_pkg::TRL_LAST) begin
                        n_idx    = '0;
                        n_state  = psd_pkg::ST_IDLE;
                        n_active = 1'b0;
                    end
                end
            end
            default: n_state = psd_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready          = (r_state == psd_pkg::ST_IDLE);
        o_cmd.src           = r_state;
        o_cmd.idx           = r_idx;
        o_cmd.fire          = w_fire;
        o_cmd.take          = (r_state == psd_pkg::ST_IDLE) && i_in_valid;
        o_cmd.latch_img     = o_cmd.take && !r_active;
        o_cmd.file_last     = (r_state == psd_pkg::ST_TRL) && (r_idx == psd_pkg::TRL_LAST);
        o_cmd.run_last      = o_cmd.file_last ||
                              ((r_state == psd_pkg::ST_PIX) && !i_sts.img_end);
    end

endmodule

[rtl/core/psd_dp.sv]
// Datapath of the stored-deflate PNG encoder: byte selection, CRC-32, Adler-32,
// length arithmetic, counters and output register. Depends on psd_pkg.
`timescale 1ns / 1ps
module psd_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  psd_pkg::t_cmd i_cmd,
    output psd_pkg::t_sts o_sts,
    input  logic [7:0]    i_pixel_byte,
    input  logic          i_cfg_valid,
    input  logic [7:0]    i_cfg_index,
    input  logic [15:0]   i_cfg_data,
    output logic          o_cfg_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_run_last,
    output logic          o_file_last
);

    logic [15:0] r_cfg_w, r_cfg_h;
    logic [15:0] r_cur_w, r_cur_h;
    logic [7:0]  r_pix;

    logic [psd_pkg::RAW_W-1:0] r_raw;
    logic [18:0] r_q0;
    logic [19:0] r_r1;
    logic [19:0] r_blocks;
    logic [31:0] r_idat_len;

    logic [psd_pkg::RAW_W-1:0] r_raw_rem;
    logic [15:0] r_blk;
    logic [17:0] r_rbc;
    logic [15:0] r_rc;
    logic [31:0] r_crc;
    logic [15:0] r_adl_lo, r_adl_hi;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_run_last, r_file_last;

    logic [17:0] w_w4;
    logic [3:0]  w_q1;
    logic [16:0] w_r2;
    logic        w_ge;
    logic [16:0] w_rem;
    logic [15:0] w_n, w_nn;
    logic        w_final;
    logic [7:0]  w_byte;
    logic        w_feed, w_init;
    logic        w_raw;
    logic [1:0]  w_k1;
    logic [31:0] w_ncrc;
    logic [16:0] w_lo_sum, w_hi_sum;
    logic [15:0] w_lo_n, w_hi_n;
    logic [18:0] w_rbc_inc;
    logic [16:0] w_rc_inc;

    assign o_cfg_ready = 1'b1;
    assign w_w4        = {r_cur_w, 2'b00};
    assign w_rbc_inc   = {1'b0, r_rbc} + 19'd1;
    assign w_rc_inc    = {1'b0, r_rc} + 17'd1;

    // Stored block count: ceil(raw / 65535) by folding the 65536 multiples.
    assign w_q1  = r_r1[19:16];
    assign w_r2  = {1'b0, r_r1[15:0]} + {13'd0, w_q1};
    assign w_ge  = (w_r2 >= {1'b0, psd_pkg::STORED_MAX});
    assign w_rem = w_ge ? (w_r2 - {1'b0, psd_pkg::STORED_MAX}) : w_r2;

    always_ff @(posedge i_clk) begin
        r_raw      <= psd_pkg::RAW_W'({17'd0, w_w4 + 18'd1} * {19'd0, r_cur_h});
        r_q0       <= r_raw[34:16];
        r_r1       <= {4'd0, r_raw[15:0]} + {1'b0, r_q0};
        r_blocks   <= {1'b0, r_q0} + {16'd0, w_q1} + {19'd0, w_ge} + {19'd0, (w_rem != '0)};
        r_idat_len <= r_raw[31:0] + 32'd6 + {10'd0, r_blocks, 2'b00} + {12'd0, r_blocks};
    end

    // Block header fields
    assign w_final = (r_raw_rem <= {19'd0, psd_pkg::STORED_MAX});
    assign w_n     = w_final ? r_raw_rem[15:0] : psd_pkg::STORED_MAX;
    assign w_nn    = ~w_n;
    assign w_k1    = i_cmd.idx[1:0] - 2'd1;

    always_comb begin
        w_byte = '0;
        w_feed = 1'b0;
        w_init = 1'b0;
        w_raw  = 1'b0;
        unique case (i_cmd.src)
            psd_pkg::ST_HDR: begin
                priority if (i_cmd.idx < 6'd8) begin
                    w_byte = psd_pkg::PNG_SIG[63 - 8*i_cmd.idx[2:0] -: 8];
                end else if (i_cmd.idx < 6'd12) begin
                    w_byte = psd_pkg::be_byte(psd_pkg::IHDR_LEN, i_cmd.idx[1:0]);
                end else if (i_cmd.idx < 6'd16) begin
                    w_byte = psd_pkg::be_byte(psd_pkg::TAG_IHDR, i_cmd.idx[1:0]);
                end else if (i_cmd.idx < 6'd20) begin
                    w_byte = psd_pkg::be_byte({16'd0, r_cur_w}, i_cmd.idx[1:0]);
                end else if (i_cmd.idx < 6'd24) begin
                    w_byte = psd_pkg::be_byte({16'd0, r_cur_h}, i_cmd.idx[1:0]);
                end else if (i_cmd.idx == 6'd24) begin
                    w_byte = psd_pkg::BIT_DEPTH;
                end else if (i_cmd.idx == 6'd25) begin
                    w_byte = psd_pkg::COLOR_RGBA;
                end else if (i_cmd.idx < 6'd29) begin
                    w_byte = '0;
                end else if (i_cmd.idx < 6'd33) begin
                    w_byte = psd_pkg::be_byte(~r_crc, w_k1);
                end else if (i_cmd.idx < 6'd37) begin
                    w_byte = psd_pkg::be_byte(r_idat_len, w_k1);
                end else if (i_cmd.idx < 6'd41) begin
                    w_byte = psd_pkg::be_byte(psd_pkg::TAG_IDAT, w_k1);
                end else if (i_cmd.idx == 6'd41) begin
                    w_byte = psd_pkg::ZLIB_CMF;
                end else begin
                    w_byte = psd_pkg::ZLIB_FLG;
                end
                w_feed = ((i_cmd.idx >= 6'd12) && (i_cmd.idx <= 6'd28)) || (i_cmd.idx >= 6'd37);
                w_init = (i_cmd.idx == 6'd12) || (i_cmd.idx == 6'd37);
            end
            psd_pkg::ST_BLK: begin
                unique case (i_cmd.idx[2:0])
                    3'd0: w_byte = {7'd0, w_final};
                    3'd1: w_byte = w_n[7:0];
                    3'd2: w_byte = w_n[15:8];
                    3'd3: w_byte = w_nn[7:0];
                    default: w_byte = w_nn[15:8];
                endcase
                w_feed = 1'b1;
            end
            psd_pkg::ST_FILT: begin
                w_byte = psd_pkg::FILTER_NONE;
                w_feed = 1'b1;
                w_raw  = 1'b1;
            end
            psd_pkg::ST_PIX: begin
                w_byte = r_pix;
                w_feed = 1'b1;
                w_raw  = 1'b1;
            end
            psd_pkg::ST_TRL: begin
                priority if (i_cmd.idx < 6'd4) begin
                    w_byte = psd_pkg::be_byte({r_adl_hi, r_adl_lo}, i_cmd.idx[1:0]);
                end else if (i_cmd.idx < 6'd8) begin
                    w_byte = psd_pkg::be_byte(~r_crc, i_cmd.idx[1:0]);
                end else if (i_cmd.idx < 6'd12) begin
                    w_byte = '0;
                end else if (i_cmd.idx < 6'd16) begin
                    w_byte = psd_pkg::be_byte(psd_pkg::TAG_IEND, i_cmd.idx[1:0]);
                end else begin
                    w_byte = psd_pkg::be_byte(~r_crc, i_cmd.idx[1:0]);
                end
                w_feed = (i_cmd.idx < 6'd4) || ((i_cmd.idx >= 6'd12) && (i_cmd.idx < 6'd16));
                w_init = (i_cmd.idx == 6'd12);
            end
            default: begin
                w_byte = '0;
            end
        endcase
    end

    assign w_ncrc   = psd_pkg::crc_byte(w_init ? psd_pkg::CRC_INIT : r_crc, w_byte);
    assign w_lo_sum = {1'b0, r_adl_lo} + {9'd0, w_byte};
    assign w_lo_n   = (w_lo_sum >= psd_pkg::ADLER_MOD) ?
                      16'(w_lo_sum - psd_pkg::ADLER_MOD) : w_lo_sum[15:0];
    assign w_hi_sum = {1'b0, r_adl_hi} + {1'b0, w_lo_n};
    assign w_hi_n   = (w_hi_sum >= psd_pkg::ADLER_MOD) ?
                      16'(w_hi_sum - psd_pkg::ADLER_MOD) : w_hi_sum[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= 16'd1;
            r_cfg_h     <= 16'd1;
            r_cur_w     <= 16'd1;
            r_cur_h     <= 16'd1;
            r_raw_rem   <= '0;
            r_blk       <= '0;
            r_rbc       <= '0;
            r_rc        <= '0;
            r_crc       <= psd_pkg::CRC_INIT;
            r_adl_lo    <= 16'd1;
            r_adl_hi    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == psd_pkg::CFG_WIDTH) begin
                    r_cfg_w <= i_cfg_data;
                end
                if (i_cfg_index == psd_pkg::CFG_HEIGHT) begin
                    r_cfg_h <= i_cfg_data;
                end
            end
            if (i_cmd.latch_img) begin
                r_cur_w <= (r_cfg_w == '0) ? 16'd1 : r_cfg_w;
                r_cur_h <= (r_cfg_h == '0) ? 16'd1 : r_cfg_h;
            end
            if (i_cmd.fire) begin
                if (w_feed) begin
                    r_crc <= w_ncrc;
                end
                if (w_raw) begin
                    r_adl_lo  <= w_lo_n;
                    r_adl_hi  <= w_hi_n;
                    r_blk     <= r_blk - 16'd1;
                    r_raw_rem <= r_raw_rem - psd_pkg::RAW_W'(1);
                end
                if ((i_cmd.src == psd_pkg::ST_BLK) && (i_cmd.idx == psd_pkg::BLK_LAST)) begin
                    r_blk <= w_n;
                end
                if (i_cmd.src == psd_pkg::ST_PIX) begin
                    if (w_rbc_inc >= {1'b0, w_w4}) begin
                        r_rbc <= '0;
                        r_rc  <= w_rc_inc[15:0];
                    end else begin
                        r_rbc <= w_rbc_inc[17:0];
                    end
                end
                if ((i_cmd.src == psd_pkg::ST_HDR) && (i_cmd.idx == psd_pkg::HDR_LAST)) begin
                    r_raw_rem <= r_raw;
                    r_blk     <= '0;
                    r_rbc     <= '0;
                    r_rc      <= '0;
                    r_adl_lo  <= 16'd1;
                    r_adl_hi  <= '0;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pix <= i_pixel_byte;
        end
        if (i_cmd.fire) begin
            r_out_byte  <= w_byte;
            r_run_last  <= i_cmd.run_last;
            r_file_last <= i_cmd.file_last;
        end
    end

    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.row_start = (r_rbc == '0);
    assign o_sts.blk_empty = (r_blk == '0);
    assign o_sts.blk_last  = (r_blk == 16'd1);
    assign o_sts.img_end   = (w_rbc_inc >= {1'b0, w_w4}) && (w_rc_inc >= {1'b0, r_cur_h});

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_run_last;
    assign o_file_last = r_file_last;

endmodule

[rtl/core/png_stored_deflate_encoder_top.sv]
// Usage notes for the stored-deflate PNG encoder.
// i_pix takes one RGBA channel byte per word, row-major, R,G,B,A per pixel.
// o_png gives the PNG file one byte per word; run_last marks the last byte
// caused by an input word, file_last the final IEND CRC byte.
// i_cfg writes image_width (index 0) and image_height (index 1); write only
// while idle. Both are sampled at the first word of each image; 0 acts as 1.
// The output register presents each byte in the cycle after it is chosen.
// The first word of an image yields 50 bytes (signature, IHDR, IDAT head,
// block header, filter byte, pixel), one per cycle when o_png is not stalled.
// A plain pixel word is accepted while idle and then gives its one byte; a
// row start adds the filter byte, a 65535-byte block boundary adds 5 header
// bytes, and the last word adds the 20-byte trailer. The sequencer emits at
// most one byte a cycle and holds while a full output register is not taken.
// A stall on o_png freezes the sequencer; i_pix.ready is high only while it
// waits for the next word, even with a byte still held at the output.
// Reset clears the sequencer, the counters and the output valid, and sets
// both registers to 1; the next word then starts a new image.
`timescale 1ns / 1ps
`include "png_stored_deflate_encoder_top_defines.svh"
module png_stored_deflate_encoder_top (
    input  logic i_clk,
    input  logic i_rst_n,
    psd_in_if.sink    i_pix,
    psd_out_if.source o_png,
    psd_cfg_if.sink   i_cfg
);

    psd_pkg::t_cmd w_cmd;
    psd_pkg::t_sts w_sts;

    // Sequencer: chooses which byte goes out each cycle
    psd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Datapath: checksums, lengths, counters, output register
    psd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_pixel_byte (i_pix.pixel_byte),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .o_cfg_ready  (i_cfg.ready),
        .o_out_valid  (o_png.valid),
        .i_out_ready  (o_png.ready),
        .o_out_byte   (o_png.out_byte),
        .o_run_last   (o_png.run_last),
        .o_file_last  (o_png.file_last)
    );

    // The file's final byte always closes the run of its input word
    `PSD_ASSERT_NOW(a_file_last_run, o_png.valid && o_png.file_last, o_png.run_last)
    // An accepted word keeps the input closed in the following cycle
    `PSD_ASSERT_NEXT(a_one_word, i_pix.valid && i_pix.ready, !i_pix.ready)
    // Never overwrite a byte the receiver has not taken
    `PSD_ASSERT_NOW(a_no_overrun, w_cmd.fire, !o_png.valid || o_png.ready)

endmodule

[tb/sv/png_encoder_checker.sv]
// Byte-stream checker for the stored-deflate PNG encoder: watches all three channels,
// predicts every PNG byte from the accepted pixel words and compares in order.
// Depends on psd_pkg and the psd_*_if interfaces.
`timescale 1ns / 1ps
module png_encoder_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    psd_in_if    pix,
    psd_out_if   png,
    psd_cfg_if   cfg,
    output int   o_fail_count,
    output int   o_pending
);
    typedef struct {
        logic [7:0] data;
        logic       run_last;
        logic       file_last;
    } png_byte_t;

    png_byte_t   png_bytes_due[$];
    logic [15:0] reg_width, reg_height;
    logic [15:0] img_width, img_height;
    bit          in_image;
    logic [17:0] row_bytes;
    logic [15:0] rows_done;
    logic [15:0] block_left;
    logic [63:0] raw_left;
    logic [31:0] crc_reg;
    logic [31:0] adler_a, adler_b;
    int          fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = png_bytes_due.size();

    function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'h0, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
        return r;
    endfunction

    task automatic put_byte(input logic [7:0] b, input bit into_crc);
        png_byte_t item;
        item.data      = b;
        item.run_last  = 1'b0;
        item.file_last = 1'b0;
        png_bytes_due.insert(png_bytes_due.size(), item);
        if (into_crc) crc_reg = crc32_next(crc_reg, b);
    endtask

    task automatic put_word(input logic [31:0] w, input bit into_crc);
        for (int k = 3; k >= 0; k--) put_byte(w[8*k +: 8], into_crc);
    endtask

    // Raw zlib payload byte, opening a new stored block where the last one ran out
    task automatic put_raw(input logic [7:0] b);
        logic [15:0] n;
        if (block_left == 0) begin
            n = (raw_left > 64'd65535) ? 16'hFFFF : raw_left[15:0];
            put_byte((raw_left <= 64'd65535) ? 8'd1 : 8'd0, 1'b1);
            put_byte(n[7:0], 1'b1);
            put_byte(n[15:8], 1'b1);
            put_byte(~n[7:0], 1'b1);
            put_byte(~n[15:8], 1'b1);
            block_left = n;
        end
        put_byte(b, 1'b1);
        adler_a = (adler_a + b) % 65521;
        adler_b = (adler_b + adler_a) % 65521;
        if (block_left != 0) block_left--;
        if (raw_left != 0) raw_left--;
    endtask

    task automatic open_image();
        logic [63:0] raw, blocks, idat_len;
        img_width  = (reg_width == 0) ? 16'd1 : reg_width;
        img_height = (reg_height == 0) ? 16'd1 : reg_height;
        raw      = (64'(img_width) * 4 + 1) * 64'(img_height);
        blocks   = (raw + 64'd65534) / 64'd65535;
        idat_len = 2 + 5 * blocks + raw + 4;
        for (int k = 7; k >= 0; k--) put_byte(psd_pkg::PNG_SIG[8*k +: 8], 1'b0);
        put_word(psd_pkg::IHDR_LEN, 1'b0);
        crc_reg = 32'hFFFFFFFF;
        put_word(psd_pkg::TAG_IHDR, 1'b1);
        put_word({16'h0, img_width}, 1'b1);
        put_word({16'h0, img_height}, 1'b1);
        put_byte(psd_pkg::BIT_DEPTH, 1'b1);
        put_byte(psd_pkg::COLOR_RGBA, 1'b1);
        repeat (3) put_byte(8'h00, 1'b1);
        put_word(~crc_reg, 1'b0);
        put_word(idat_len[31:0], 1'b0);
        crc_reg = 32'hFFFFFFFF;
        put_word(psd_pkg::TAG_IDAT, 1'b1);
        put_byte(psd_pkg::ZLIB_CMF, 1'b1);
        put_byte(psd_pkg::ZLIB_FLG, 1'b1);
        raw_left   = raw;
        block_left = 0;
        row_bytes  = 0;
        rows_done  = 0;
        adler_a    = 1;
        adler_b    = 0;
        in_image   = 1'b1;
    endtask

    task automatic close_image();
        put_word({adler_b[15:0], adler_a[15:0]}, 1'b1);
        put_word(~crc_reg, 1'b0);
        put_word(32'h0, 1'b0);
        crc_reg = 32'hFFFFFFFF;
        put_word(psd_pkg::TAG_IEND, 1'b1);
        put_word(~crc_reg, 1'b0);
        png_bytes_due[$].file_last = 1'b1;
        in_image = 1'b0;
    endtask

    task automatic take_pixel(input logic [7:0] b);
        if (!in_image) open_image();
        if (row_bytes == 0) put_raw(psd_pkg::FILTER_NONE);
        put_raw(b);
        row_bytes++;
        if (row_bytes >= 18'(img_width) * 4) begin
            row_bytes = 0;
            rows_done++;
            if (rows_done >= img_height) close_image();
        end
        png_bytes_due[$].run_last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        png_byte_t want;
        if (!i_rst_n) begin
            reg_width  = 16'd1;
            reg_height = 16'd1;
            in_image   = 1'b0;
            crc_reg    = 32'hFFFFFFFF;
            fail_count = 0;
            png_bytes_due.delete();
        end else begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == psd_pkg::CFG_WIDTH) reg_width = cfg.data;
                else if (cfg.index == psd_pkg::CFG_HEIGHT) reg_height = cfg.data;
            end
            if (pix.valid && pix.ready) take_pixel(pix.pixel_byte);
            if (png.valid && png.ready) begin
                if (png_bytes_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected PNG byte %h", png.out_byte);
                end else begin
                    want = png_bytes_due.pop_front();
                    if (png.out_byte !== want.data || png.run_last !== want.run_last ||
                        png.file_last !== want.file_last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("PNG byte mismatch: exp %h/%b/%b got %h/%b/%b",
                                     want.data, want.run_last, want.file_last,
                                     png.out_byte, png.run_last, png.file_last);
                    end
                end
            end
        end
    end
endmodule

[tb/sv/tb_top.sv]
// Top of the stored-deflate PNG encoder testbench: clock, reset, stimulus and verdict.
// Depends on psd_pkg, the psd_*_if interfaces, png_encoder_checker and the encoder RTL.
`timescale 1ns / 1ps
module tb_top;

    localparam int STALL_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count, bytes_pending;
    int   idle_cycles = 0;
    int   out_hold = 0;
    bit   quiet = 1'b0;     // no idling on either side in the closing stretch

    psd_in_if  pix();
    psd_out_if png();
    psd_cfg_if cfg();

    always #6 i_clk = ~i_clk;

    png_stored_deflate_encoder_top dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix),
        .o_png  (png),
        .i_cfg  (cfg)
    );

    png_encoder_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .pix         (pix),
        .png         (png),
        .cfg         (cfg),
        .o_fail_count(fail_count),
        .o_pending   (bytes_pending)
    );

    // Output back-pressure: occasional random bursts of stalled cycles
    always @(posedge i_clk) begin
        if (out_hold > 0) begin
            out_hold <= out_hold - 1;
            png.ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            out_hold <= $urandom_range(0, 11);
            png.ready <= 1'b0;
        end else begin
            png.ready <= 1'b1;
        end
    end

    // Watchdog: give up once no word has moved on any channel for too long
    always @(posedge i_clk) begin
        if ((pix.valid && pix.ready) || (png.valid && png.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Drop both valids and wait until every expected byte is out, plus a margin
    // for the output register to drain
    task automatic settle();
        pix.valid <= 1'b0;
        cfg.valid <= 1'b0;
        @(posedge i_clk);
        while (bytes_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Leaves valid high; the next settle lowers it
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] value);
        cfg.index <= idx;
        cfg.data  <= value;
        cfg.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
    endtask

    // Hold off for a random burst now and then, then present the word until taken
    task automatic send_word(input logic [7:0] b, input int gap_odds);
        if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        pix.valid      <= 1'b1;
        pix.pixel_byte <= b;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
    endtask

    task automatic send_image(input int w, input int h, input int gap_odds);
        int n;
        n = (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * 4;
        for (int k = 0; k < n; k++) send_word(8'($urandom), gap_odds);
    endtask

    initial begin
        int done, w, h;
        pix.valid = 1'b0;
        pix.pixel_byte = 8'h00;
        cfg.valid = 1'b0;
        cfg.index = psd_pkg::CFG_WIDTH;
        cfg.data = 16'h0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset size 1x1: all-zero and all-one channel bytes
        send_word(8'h00, 0); send_word(8'hFF, 0); send_word(8'hAA, 0); send_word(8'h55, 0);
        settle();
        // Zero size acts as one
        write_reg(psd_pkg::CFG_WIDTH, 16'h0000); settle();
        write_reg(psd_pkg::CFG_HEIGHT, 16'h0000); settle();
        send_word(8'hFF, 0); send_word(8'h00, 0); send_word(8'h55, 0); send_word(8'hAA, 0);
        settle();
        // Two rows of two pixels, with a write mid-image that must wait for the next one
        write_reg(psd_pkg::CFG_WIDTH, 16'd2); settle();
        write_reg(psd_pkg::CFG_HEIGHT, 16'd2); settle();
        for (int k = 0; k < 8; k++) send_word(8'(k * 37), 2);
        settle();
        write_reg(psd_pkg::CFG_WIDTH, 16'd1); settle();
        for (int k = 0; k < 8; k++) send_word(8'(255 - k), 2);
        settle();

        // Random small images, the last part with no idling
        done = 0;
        while (done < 230) begin
            if (done > 170) quiet = 1'b1;
            w = $urandom_range(0, 6);
            h = $urandom_range(0, 3);
            write_reg(psd_pkg::CFG_WIDTH, 16'(w)); settle();
            write_reg(psd_pkg::CFG_HEIGHT, 16'(h)); settle();
            send_image(w, h, 6);
            settle();
            done += (w == 0 ? 1 : w) * (h == 0 ? 1 : h) * 4;
        end

        // Register extremes: opening of a maximum-size image, whose IDAT length wraps
        write_reg(psd_pkg::CFG_WIDTH, 16'hFFFF); settle();
        write_reg(psd_pkg::CFG_HEIGHT, 16'hFFFF); settle();
        for (int k = 0; k < 8; k++) send_word(8'($urandom), 0);
        settle();

        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && bytes_pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/psd_pkg.sv
rtl/core/psd_in_if.sv
rtl/core/psd_out_if.sv
rtl/core/psd_cfg_if.sv
rtl/core/psd_ctrl.sv
rtl/core/psd_dp.sv
rtl/core/png_stored_deflate_encoder_top.sv
tb/sv/png_encoder_checker.sv
tb/sv/tb_top.sv
